FILE: rtl/sprt_pkg.sv
package sprt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_COUNT_BITS  = 16;
   localparam int PAGE_ADDR_BITS      = 32;
   localparam int RSP_COUNT_BITS      = 16;

   // request opcodes
   localparam logic OP_SHARE   = 1'b0;
   localparam logic OP_UNSHARE = 1'b1;

   // response status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture request, restart scan
      logic scan;    // read table entry at scan index
      logic update;  // apply result, write table, issue response
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

FILE: rtl/sprt_ram.sv
module sprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sprt_ctrl.sv
module sprt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sprt_pkg::dp_status_type dp_status,
   output sprt_pkg::dp_cmd_type    dp_cmd
);

   import sprt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy          = busy_ff;
   assign dp_cmd.load   = start & ~busy_ff;
   assign dp_cmd.scan   = (state_ff == ST_SCAN);
   assign dp_cmd.update = (state_ff == ST_UPDATE);

endmodule

FILE: rtl/sprt_dp.sv
module sprt_dp #(
   parameter int TABLE_DEPTH = sprt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COUNT_BITS  = sprt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sprt_pkg::dp_cmd_type                dp_cmd,
   output sprt_pkg::dp_status_type             dp_status,
   input  logic                                req_opcode,
   input  logic [sprt_pkg::PAGE_ADDR_BITS-1:0] req_page_addr,
   output logic                                rsp_valid,
   output logic                                rsp_status,
   output logic [sprt_pkg::RSP_COUNT_BITS-1:0] rsp_share_count,
   output logic                                rsp_was_present
);

   import sprt_pkg::*;

   localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS = PAGE_ADDR_BITS + COUNT_BITS;

   logic                      op_ff;
   logic [PAGE_ADDR_BITS-1:0] addr_ff;
   logic [IDX_BITS-1:0]       scan_idx_ff, scan_idx_in;
   logic [IDX_BITS-1:0]       cmp_idx_ff;
   logic                      cmp_vld_ff;
   logic                      hit_ff, hit_in;
   logic [IDX_BITS-1:0]       hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0]     hit_cnt_ff, hit_cnt_in;
   logic                      free_ff, free_in;
   logic [IDX_BITS-1:0]       free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0]    valid_ff, valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic [RSP_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                      rsp_present_ff, rsp_present_in;

   logic                      wr_en;
   logic [IDX_BITS-1:0]       wr_addr;
   logic [COUNT_BITS-1:0]     wr_cnt;
   logic [ENTRY_BITS-1:0]     rd_data;
   logic [PAGE_ADDR_BITS-1:0] rd_addr_field;
   logic [COUNT_BITS-1:0]     rd_cnt_field;
   logic                      cmp_entry_valid;
   logic [COUNT_BITS-1:0]     cnt_max;
   logic [COUNT_BITS-1:0]     cnt_reported;
   logic [RSP_COUNT_BITS+COUNT_BITS-1:0] cnt_wide;

   function automatic logic req_op_is_share(input logic op);
      return (op == OP_SHARE);
   endfunction

   sprt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({addr_ff, wr_cnt}),
      .rd_en   (dp_cmd.scan),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_addr_field   = rd_data[ENTRY_BITS-1 -: PAGE_ADDR_BITS];
   assign rd_cnt_field    = rd_data[COUNT_BITS-1:0];
   assign cmp_entry_valid = valid_ff[cmp_idx_ff];
   assign cnt_max         = {COUNT_BITS{1'b1}};

   assign dp_status.scan_last = (scan_idx_ff == IDX_BITS'(TABLE_DEPTH - 1));

   // scan and compare: the compare stage works on each entry in the cycle after its read
   always_comb begin
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (dp_cmd.load) begin
         scan_idx_in = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
      end else begin
         if (dp_cmd.scan) begin
            scan_idx_in = scan_idx_ff + IDX_BITS'(1);
         end
         if (cmp_vld_ff) begin
            // keep the lowest match and the lowest free slot
            if (cmp_entry_valid && (rd_addr_field == addr_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_cnt_in = rd_cnt_field;
            end
            if (!cmp_entry_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
         end
      end
   end

   // update step
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = hit_idx_ff;
      wr_cnt         = hit_cnt_ff;
      valid_in       = valid_ff;
      cnt_reported   = '0;
      rsp_valid_in   = dp_cmd.update;
      rsp_status_in  = STATUS_DONE;
      rsp_present_in = 1'b0;
      if (dp_cmd.update) begin
         if (req_op_is_share(op_ff)) begin
            if (hit_ff) begin
               wr_en          = 1'b1;
               wr_cnt         = (hit_cnt_ff == cnt_max) ? hit_cnt_ff
                                                        : hit_cnt_ff + COUNT_BITS'(1);
               cnt_reported   = wr_cnt;
               rsp_present_in = 1'b1;
            end else if (free_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               wr_cnt                = COUNT_BITS'(1);
               valid_in[free_idx_ff] = 1'b1;
               cnt_reported          = COUNT_BITS'(1);
            end else begin
               rsp_status_in = STATUS_FULL;
            end
         end else if (hit_ff) begin
            cnt_reported   = hit_cnt_ff;
            rsp_present_in = 1'b1;
            if (hit_cnt_ff == '0) begin
               valid_in[hit_idx_ff] = 1'b0;
            end else begin
               wr_en  = 1'b1;
               wr_cnt = hit_cnt_ff - COUNT_BITS'(1);
            end
         end
      end
      cnt_wide     = {{RSP_COUNT_BITS{1'b0}}, cnt_reported};
      rsp_count_in = cnt_wide[RSP_COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         cmp_vld_ff   <= dp_cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff   <= req_opcode;
         addr_ff <= req_page_addr;
      end
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= scan_idx_ff;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_cnt_ff     <= hit_cnt_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_share_count = rsp_count_ff;
   assign rsp_was_present = rsp_present_ff;

endmodule

FILE: rtl/shared_page_refcount_table.sv
// Copy-on-write page share-count table. A request (req_opcode, req_page_addr) is
// taken on a clock edge with start high and busy low. A share request bumps the
// count of a matching page (saturating at all ones) or claims the lowest free
// entry with count 1; with no free entry it answers status full. An unshare
// request returns the old count and decrements it, or frees the entry when the
// old count was already zero; a miss answers zero. Each request yields exactly
// one response, shown for a single cycle with rsp_valid high; the receiver
// cannot stall it, so sample it on that cycle. To answer, the controller
// walks the whole entry memory one read per cycle, then passes a wait state
// for the last compare and an update state, whose result lands in the
// response register. The next request may be issued in the cycle the
// response is shown, as busy falls with the strobe; no request is taken
// while busy. Valid bits clear at reset; no clearing pass is needed, so the
// block takes requests right after reset.
module shared_page_refcount_table #(
   parameter int TABLE_DEPTH = sprt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COUNT_BITS  = sprt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [sprt_pkg::PAGE_ADDR_BITS-1:0] req_page_addr,
   output logic                                rsp_valid,
   output logic                                rsp_status,
   output logic [sprt_pkg::RSP_COUNT_BITS-1:0] rsp_share_count,
   output logic                                rsp_was_present
);

   import sprt_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequence the scan and the update step
   sprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // hold the request, the entry memory, valid bits and the response register
   sprt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .req_opcode      (req_opcode),
      .req_page_addr   (req_page_addr),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_share_count (rsp_share_count),
      .rsp_was_present (rsp_was_present)
   );

`ifndef SYNTHESIS
   // a response strobe follows only an update step
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(dp_cmd.update))
      else $error("response strobe without update step");

   // an update step always yields a response on the next cycle
   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.update |=> rsp_valid)
      else $error("update step without response strobe");

   // responses never come back to back: each needs a full scan
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two response strobes in a row");

   // a table-full answer carries no count and no hit
   a_full_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_share_count == '0 && !rsp_was_present))
      else $error("table full response with count or hit");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   import sprt_pkg::*;

   // Run the block at its default table depth and count width.
   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CNT_BITS    = DEFAULT_COUNT_BITS;
   localparam int POOL_SIZE   = 80;
   localparam int NUM_RANDOM  = 400;

   localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic                      drain;   // hold the sender until all responses are in
      logic                      opcode;
      logic [PAGE_ADDR_BITS-1:0] page_addr;
   } page_req_type;

   typedef struct packed {
      logic                      status;
      logic [RSP_COUNT_BITS-1:0] share_count;
      logic                      was_present;
   } page_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_opcode = OP_SHARE;
   logic [PAGE_ADDR_BITS-1:0] req_page_addr = '0;
   logic                      rsp_valid;
   logic                      rsp_status;
   logic [RSP_COUNT_BITS-1:0] rsp_share_count;
   logic                      rsp_was_present;

   shared_page_refcount_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (CNT_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_page_addr   (req_page_addr),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_share_count (rsp_share_count),
      .rsp_was_present (rsp_was_present)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be sent, and responses the table mirror predicts.
   page_req_type pending_reqs[$];
   page_rsp_type expected_rsps[$];

   // Mirror of the share table.
   logic                      tbl_valid [TABLE_DEPTH];
   logic [PAGE_ADDR_BITS-1:0] tbl_addr  [TABLE_DEPTH];
   logic [CNT_BITS-1:0]       tbl_count [TABLE_DEPTH];

   logic [PAGE_ADDR_BITS-1:0] page_pool [POOL_SIZE];

   int  error_count    = 0;
   int  rsp_checked    = 0;
   int  shares_sent    = 0;
   int  unshares_sent  = 0;
   int  full_seen      = 0;
   int  saturated_seen = 0;
   int  freed_seen     = 0;
   int  gap_left       = 0;
   logic burst_mode    = 1'b0;

   // Apply one request to the mirror and return the response it must give.
   function automatic page_rsp_type apply_page_request(logic op,
                                                       logic [PAGE_ADDR_BITS-1:0] addr);
      page_rsp_type rsp;
      int           hit;
      int           slot;
      rsp  = '0;
      rsp.status = STATUS_DONE;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr) hit = i;
         if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (op == OP_SHARE) begin
         if (hit >= 0) begin
            // saturate at all ones and report the held value
            if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + CNT_BITS'(1);
            else saturated_seen++;
            rsp.share_count = RSP_COUNT_BITS'(tbl_count[hit]);
            rsp.was_present = 1'b1;
         end else if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_addr[slot]  = addr;
            tbl_count[slot] = CNT_BITS'(1);
            rsp.share_count = RSP_COUNT_BITS'(1);
         end else begin
            rsp.status = STATUS_FULL;
            full_seen++;
         end
      end else if (hit >= 0) begin
         // report the old count; an entry already at zero is released
         rsp.share_count = RSP_COUNT_BITS'(tbl_count[hit]);
         rsp.was_present = 1'b1;
         if (tbl_count[hit] == '0) begin
            tbl_valid[hit] = 1'b0;
            freed_seen++;
         end else begin
            tbl_count[hit] = tbl_count[hit] - CNT_BITS'(1);
         end
      end
      return rsp;
   endfunction

   // Gap before the next request: none in burst mode, else a random draw.
   function automatic int draw_gap();
      if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      return burst_mode ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic queue_request(logic op, logic [PAGE_ADDR_BITS-1:0] addr);
      page_req_type req;
      req.drain     = 1'b0;
      req.opcode    = op;
      req.page_addr = addr;
      pending_reqs.push_back(req);
   endtask

   task automatic queue_drain();
      page_req_type req;
      req = '0;
      req.drain = 1'b1;
      pending_reqs.push_back(req);
   endtask

   // Driver: present one request at a time and hold it until busy is low
   // at an edge. The mirror is updated at the edge that takes the request,
   // long before its response can come back.
   always @(posedge clock) begin : driver
      page_req_type nxt;
      logic         issue;
      issue = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_page_request(req_opcode, req_page_addr));
            if (req_opcode == OP_SHARE) shares_sent++;
            else unshares_sent++;
         end
         if (!(start && busy)) begin
            // release a drain marker only once every response is in
            if (pending_reqs.size() != 0 && pending_reqs[0].drain &&
                expected_rsps.size() == 0) begin
               void'(pending_reqs.pop_front());
            end
            if (gap_left > 0 && !busy) begin
               gap_left--;
            end else if (gap_left == 0 && pending_reqs.size() != 0 &&
                         !pending_reqs[0].drain) begin
               nxt = pending_reqs.pop_front();
               req_opcode    <= nxt.opcode;
               req_page_addr <= nxt.page_addr;
               gap_left = draw_gap();
               issue = 1'b1;
            end
            start <= issue;
         end
      end
   end

   // Monitor: every strobe must match the oldest predicted response.
   always @(posedge clock) begin : monitor
      page_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR %0t: unexpected response status=%0b count=%0d present=%0b",
                        $time, rsp_status, rsp_share_count, rsp_was_present);
         end else begin
            want = expected_rsps.pop_front();
            rsp_checked++;
            if (rsp_status !== want.status || rsp_share_count !== want.share_count ||
                rsp_was_present !== want.was_present) begin
               error_count++;
               if (error_count <= 10) begin
                  $write("ERROR %0t: response %0d expected status=%0b count=%0d present=%0b,",
                         $time, rsp_checked, want.status, want.share_count,
                         want.was_present);
                  $display(" got status=%0b count=%0d present=%0b",
                           rsp_status, rsp_share_count, rsp_was_present);
               end
            end
         end
      end
   end

   // Stimulus: directed corner cases, then random request sequences.
   initial begin : stimulus
      logic [PAGE_ADDR_BITS-1:0] addr;
      int total;
      int kind;
      int idx;
      int reps;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i]  = '0;
         tbl_count[i] = '0;
      end

      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         page_pool[i] = (i % 2 == 0) ? ($urandom() & 32'hFFFF_F000) : $urandom();

      // Share and release the all-ones page down to the free step, then
      // miss on it and on a never-seen page.
      queue_request(OP_SHARE,   '1);
      queue_request(OP_SHARE,   '1);
      queue_request(OP_UNSHARE, '1);
      queue_request(OP_UNSHARE, '1);
      queue_request(OP_UNSHARE, '1);
      queue_request(OP_UNSHARE, '1);
      queue_request(OP_UNSHARE, 32'h1234_5678);
      // Share page zero a few times, then release it once.
      for (int i = 0; i < 3; i++) queue_request(OP_SHARE, '0);
      queue_request(OP_UNSHARE, '0);
      // Hold the sender until the table has answered everything.
      queue_drain();

      total = 0;
      while (total < NUM_RANDOM) begin
         kind = $urandom_range(0, 99);
         idx  = $urandom_range(0, POOL_SIZE - 1);
         if (kind < 30) begin
            // spread shares over neighboring pool pages to fill the table
            for (int i = 0; i < 8; i++)
               queue_request(OP_SHARE, page_pool[(idx + i) % POOL_SIZE]);
            total += 8;
         end else if (kind < 45) begin
            // hammer one page
            reps = $urandom_range(1, 20);
            for (int i = 0; i < reps; i++) queue_request(OP_SHARE, page_pool[idx]);
            total += reps;
         end else if (kind < 70) begin
            // release one page, often far enough to free it
            reps = $urandom_range(1, 18);
            for (int i = 0; i < reps; i++) queue_request(OP_UNSHARE, page_pool[idx]);
            total += reps;
         end else if (kind < 90) begin
            queue_request(logic'($urandom_range(0, 1)), page_pool[idx]);
            total++;
         end else begin
            addr = $urandom();
            queue_request(logic'($urandom_range(0, 1)), addr);
            total++;
         end
         if ($urandom_range(0, 39) == 0) queue_drain();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("Checked %0d responses to %0d share and %0d unshare requests.",
               rsp_checked, shares_sent, unshares_sent);
      $display("Saw %0d table-full answers, %0d saturated shares, %0d freed entries.",
               full_seen, saturated_seen, freed_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout: %0d responses still outstanding", expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sprt_pkg.sv
rtl/sprt_ram.sv
rtl/sprt_ctrl.sv
rtl/sprt_dp.sv
rtl/shared_page_refcount_table.sv
sim/testbench.sv
